### sv/char_fifo_with_newline_tracking_unit_assert.svh
// Assertion macros for the character queue RTL, included by the pointer control.
// Depends on nothing; assertions are sampled on clk and disabled while rst_n is low.
`ifndef CHAR_FIFO_WITH_NEWLINE_TRACKING_UNIT_ASSERT_SVH
`define CHAR_FIFO_WITH_NEWLINE_TRACKING_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define CFNT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that, once seen, must be followed by another in the next cycle.
`define CFNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFNT_ASSERT(lbl, prop, msg)
`define CFNT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/cfnt_pkg.sv
// Shared types and constants of the character queue with newline tracking.
// Used by the pointer control and the top level; depends on nothing.
package cfnt_pkg;

  // Queue geometry: one slot is always kept free.
  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CHAR_W = 8;

  // Special bytes.
  localparam logic [CHAR_W-1:0] NEWLINE_BYTE   = 8'd10;
  localparam logic [CHAR_W-1:0] EMPTY_UNINSERT = 8'd36;
  localparam logic [CHAR_W-1:0] EMPTY_REMOVE   = 8'd33;
  localparam logic [CHAR_W-1:0] NO_CHAR        = 8'd0;

  // Operation codes carried on the mode field.
  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_UNINSERT = 2'd1,
    MODE_REMOVE   = 2'd2
  } mode_t;

  // Access to the byte storage issued by the control logic.
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [CHAR_W-1:0] wdata;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

  // Result beat assembled by the control logic and registered in the cycle after the command.
  typedef struct packed {
    logic              valid;
    logic              use_ram;
    logic [CHAR_W-1:0] fixed_char;
    logic              done_res;
    logic              is_empty;
    logic              is_full;
    logic              has_newline;
  } res_t;

  // Ring pointer steps for any depth.
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

endpackage

### sv/cfnt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module cfnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/cfnt_ctrl.sv
// Pointer and newline-mark control of the character queue.
// Depends on cfnt_pkg and the assertion macro header.
`include "char_fifo_with_newline_tracking_unit_assert.svh"

module cfnt_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [1:0]                  mode,
  input  logic [cfnt_pkg::CHAR_W-1:0] char_in,
  output cfnt_pkg::ram_req_t          ram_req,
  output cfnt_pkg::res_t              res
);

  logic [cfnt_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [cfnt_pkg::PTR_W-1:0] tail_r, tail_nxt;
  logic [cfnt_pkg::PTR_W-1:0] nl_r, nl_nxt;
  cfnt_pkg::res_t             res_r, res_nxt;
  logic [cfnt_pkg::PTR_W-1:0] tail_inc, tail_dec;
  logic                       empty_now, full_now, empty_nxt;

  assign tail_inc  = cfnt_pkg::ptr_next(tail_r);
  assign tail_dec  = cfnt_pkg::ptr_prev(tail_r);
  assign empty_now = (head_r == tail_r);
  assign full_now  = (tail_inc == head_r);

  // Decode the command, update the pointers and issue the storage access.
  always_comb begin
    head_nxt            = head_r;
    tail_nxt            = tail_r;
    nl_nxt              = nl_r;
    ram_req.we          = 1'b0;
    ram_req.waddr       = tail_r;
    ram_req.wdata       = char_in;
    ram_req.raddr       = head_r;
    res_nxt.valid       = accept;
    res_nxt.use_ram     = 1'b0;
    res_nxt.fixed_char  = cfnt_pkg::NO_CHAR;
    res_nxt.done_res    = 1'b0;
    if (accept) begin
      unique case (cfnt_pkg::mode_t'(mode))
        cfnt_pkg::MODE_INSERT: begin
          if (!full_now) begin
            ram_req.we = 1'b1;
            if (char_in == cfnt_pkg::NEWLINE_BYTE) begin
              nl_nxt = tail_r;
            end else if (nl_r == tail_r) begin
              nl_nxt = tail_inc;
            end
            tail_nxt         = tail_inc;
            res_nxt.done_res = 1'b1;
          end
        end
        cfnt_pkg::MODE_UNINSERT: begin
          if (empty_now) begin
            res_nxt.fixed_char = cfnt_pkg::EMPTY_UNINSERT;
          end else begin
            if (nl_r == tail_r) begin
              nl_nxt = tail_dec;
            end
            tail_nxt         = tail_dec;
            ram_req.raddr    = tail_dec;
            res_nxt.use_ram  = 1'b1;
            res_nxt.done_res = 1'b1;
          end
        end
        cfnt_pkg::MODE_REMOVE: begin
          if (empty_now) begin
            res_nxt.fixed_char = cfnt_pkg::EMPTY_REMOVE;
          end else begin
            if (nl_r == head_r) begin
              nl_nxt = tail_r;
            end
            head_nxt         = cfnt_pkg::ptr_next(head_r);
            res_nxt.use_ram  = 1'b1;
            res_nxt.done_res = 1'b1;
          end
        end
        default: begin
          // Unused code: nothing changes.
        end
      endcase
    end
    empty_nxt           = (head_nxt == tail_nxt);
    res_nxt.is_empty    = empty_nxt;
    res_nxt.is_full     = (cfnt_pkg::ptr_next(tail_nxt) == head_nxt);
    res_nxt.has_newline = !empty_nxt && (nl_nxt != tail_nxt);
  end

  // Pointer state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      nl_r         <= '0;
      res_r.valid  <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      nl_r         <= nl_nxt;
      res_r.valid  <= res_nxt.valid;
    end
    res_r.use_ram     <= res_nxt.use_ram;
    res_r.fixed_char  <= res_nxt.fixed_char;
    res_r.done_res    <= res_nxt.done_res;
    res_r.is_empty    <= res_nxt.is_empty;
    res_r.is_full     <= res_nxt.is_full;
    res_r.has_newline <= res_nxt.has_newline;
  end

  assign res = res_r;

  // Checks on the pointer logic.
  `CFNT_ASSERT(a_not_empty_and_full, !(empty_now && full_now), "queue both empty and full")
  `CFNT_ASSERT_NEXT(a_insert_fills, accept && (mode == cfnt_pkg::MODE_INSERT) && !full_now, res_r.valid && !res_r.is_empty, "insert left queue empty")
  `CFNT_ASSERT_NEXT(a_idle_holds, !accept, $stable(head_r) && $stable(tail_r) && !res_r.valid, "pointers moved without a command")
  `CFNT_ASSERT(a_newline_needs_data, !(res_r.valid && res_r.has_newline && res_r.is_empty), "newline flagged on empty queue")

endmodule

### sv/char_fifo_with_newline_tracking_unit.sv
// Top level of the character queue with newline tracking.
// Depends on cfnt_pkg, cfnt_ctrl and cfnt_ram.
//
//   channel   ports                                           handshake
//   command   start, busy, in_mode, in_char_in                start && !busy
//   result    out_valid, out_char_out, out_done_res,          out_valid, one cycle
//             out_is_empty, out_is_full, out_has_newline
//
// A command is taken in any cycle; busy stays low, so one beat per cycle is sustained.
// Its result beat appears in the next cycle, set by the registered read of the
// byte storage RAM. Pointers live in flops, so a write is visible to the next command.
// Reset is synchronous and active low; it clears the pointers and needs no RAM sweep.
// The receiver cannot stall; results are never held.
module char_fifo_with_newline_tracking_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [cfnt_pkg::CHAR_W-1:0] in_char_in,
  output logic                        out_valid,
  output logic [cfnt_pkg::CHAR_W-1:0] out_char_out,
  output logic                        out_done_res,
  output logic                        out_is_empty,
  output logic                        out_is_full,
  output logic                        out_has_newline
);

  cfnt_pkg::ram_req_t          ram_req;
  cfnt_pkg::res_t              res;
  logic [cfnt_pkg::CHAR_W-1:0] ram_rdata;
  logic                        accept;

  // The queue never stalls a command.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  cfnt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .mode    (in_mode),
    .char_in (in_char_in),
    .ram_req (ram_req),
    .res     (res)
  );

  cfnt_ram #(
    .WIDTH (cfnt_pkg::CHAR_W),
    .DEPTH (cfnt_pkg::DEPTH)
  ) u_storage (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Result beat: the byte comes from storage or is a fixed code.
  assign out_valid       = res.valid;
  assign out_char_out    = res.use_ram ? ram_rdata : res.fixed_char;
  assign out_done_res    = res.done_res;
  assign out_is_empty    = res.is_empty;
  assign out_is_full     = res.is_full;
  assign out_has_newline = res.has_newline;

endmodule

### tb/char_fifo_with_newline_tracking_unit_tb.sv
// Self-checking testbench for the character queue with newline tracking.
// Depends on cfnt_pkg and the char_fifo_with_newline_tracking_unit RTL; it predicts every
// result beat from its own model of the ring buffer and compares it field by field.
module char_fifo_with_newline_tracking_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfnt_pkg::*;

  // The mode field has one code that no operation uses.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int TARGET_ITEMS = 750;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAR_W-1:0] ch;
    logic [7:0]        gap;
  } cmd_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              done_res;
    logic              is_empty;
    logic              is_full;
    logic              has_newline;
  } queue_result_t;

  // Clock, reset and block inputs, all known from time zero.
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [1:0]        in_mode = MODE_INSERT;
  logic [CHAR_W-1:0] in_char_in = NO_CHAR;
  logic              busy;
  logic              out_valid;
  logic [CHAR_W-1:0] out_char_out;
  logic              out_done_res;
  logic              out_is_empty;
  logic              out_is_full;
  logic              out_has_newline;

  // Command backlog, expected result beats and bookkeeping.
  cmd_item_t     cmd_backlog[$];
  queue_result_t pending_results[$];
  logic          cmd_taken = 1'b0;
  int            wait_left = 0;
  int            quiet_left = 0;
  int            n_items = 0;
  int            mismatches = 0;
  int            beats_checked = 0;
  int            ops_seen[4];
  int            full_drops = 0;
  int            empty_hits = 0;
  int            full_flags = 0;
  int            newline_flags = 0;

  // Private copy of the queue state.
  logic [CHAR_W-1:0] ring_bytes[DEPTH];
  logic [PTR_W-1:0]  ring_head = '0;
  logic [PTR_W-1:0]  ring_tail = '0;
  logic [PTR_W-1:0]  ring_mark = '0;

  char_fifo_with_newline_tracking_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_char_out   (out_char_out),
    .out_done_res   (out_done_res),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full),
    .out_has_newline(out_has_newline)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [PTR_W-1:0] ring_fwd(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + 1) % DEPTH);
  endfunction

  function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] p);
    return PTR_W'((int'(p) + DEPTH - 1) % DEPTH);
  endfunction

  // Applies one operation to the private queue and returns the beat it should produce.
  task automatic predict_queue_op(input logic [1:0] mode, input logic [CHAR_W-1:0] ch,
                                  output queue_result_t res);
    logic [PTR_W-1:0] step;
    logic             was_empty;
    logic             was_full;
    res = '0;
    res.char_out = NO_CHAR;
    was_empty = (ring_head == ring_tail);
    was_full = (ring_fwd(ring_tail) == ring_head);
    case (mode)
      MODE_INSERT: begin
        if (!was_full) begin
          step = ring_fwd(ring_tail);
          if (ch == NEWLINE_BYTE) ring_mark = ring_tail;
          else if (ring_mark == ring_tail) ring_mark = step;
          ring_bytes[ring_tail] = ch;
          ring_tail = step;
          res.done_res = 1'b1;
        end
      end
      MODE_UNINSERT: begin
        if (was_empty) begin
          res.char_out = EMPTY_UNINSERT;
        end else begin
          step = ring_back(ring_tail);
          if (ring_mark == ring_tail) ring_mark = step;
          ring_tail = step;
          res.char_out = ring_bytes[ring_tail];
          res.done_res = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (was_empty) begin
          res.char_out = EMPTY_REMOVE;
        end else begin
          res.char_out = ring_bytes[ring_head];
          if (ring_mark == ring_head) ring_mark = ring_tail;
          ring_head = ring_fwd(ring_head);
          res.done_res = 1'b1;
        end
      end
      default: begin
        // The unused code leaves the queue untouched.
      end
    endcase
    res.is_empty = (ring_head == ring_tail);
    res.is_full = (ring_fwd(ring_tail) == ring_head);
    res.has_newline = !res.is_empty && (ring_mark != ring_tail);
    if (mode == MODE_INSERT && was_full) full_drops++;
    if ((mode == MODE_UNINSERT || mode == MODE_REMOVE) && was_empty) empty_hits++;
  endtask

  // Queues one command with the idle time that follows it. Most gaps are short, a few
  // long, and now and then a stretch of commands runs back to back.
  task automatic push_cmd(input logic [1:0] mode, input logic [CHAR_W-1:0] ch);
    cmd_item_t item;
    int        roll;
    item.mode = mode;
    item.ch = ch;
    item.gap = '0;
    if (quiet_left > 0) begin
      quiet_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 5) quiet_left = $urandom_range(20, 80);
      else if (roll < 50) item.gap = '0;
      else if (roll < 85) item.gap = 8'($urandom_range(1, 3));
      else if (roll < 97) item.gap = 8'($urandom_range(4, 12));
      else item.gap = 8'($urandom_range(20, 60));
    end
    cmd_backlog.push_back(item);
    if (mode != MODE_UNUSED) n_items++;
  endtask

  // Random byte with newlines well represented.
  function automatic logic [CHAR_W-1:0] pick_char();
    return ($urandom_range(0, 4) == 0) ? NEWLINE_BYTE : CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Driver: presents the next command beat at the falling edge once the current one is taken.
  always @(negedge clk) begin : drive_cmds
    cmd_item_t item;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || cmd_taken) begin
      if (wait_left > 0) begin
        wait_left <= wait_left - 1;
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        item = cmd_backlog.pop_front();
        in_mode <= item.mode;
        in_char_in <= item.ch;
        start <= 1'b1;
        wait_left <= int'(item.gap);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: logs accepted command beats into the prediction and checks result beats.
  always @(posedge clk) begin : watch_beats
    queue_result_t want;
    queue_result_t got;
    if (!rst_n) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= start && !busy;
      if (start && !busy) begin
        predict_queue_op(in_mode, in_char_in, want);
        pending_results.push_back(want);
        ops_seen[in_mode]++;
      end
      if (out_valid) begin
        got = '{out_char_out, out_done_res, out_is_empty, out_is_full, out_has_newline};
        beats_checked++;
        if (got.is_full) full_flags++;
        if (got.has_newline) newline_flags++;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result beat with no command outstanding: %p", got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            note_mismatch($sformatf("expected char=%02h done=%b empty=%b full=%b nl=%b, got char=%02h done=%b empty=%b full=%b nl=%b",
                                    want.char_out, want.done_res, want.is_empty,
                                    want.is_full, want.has_newline, got.char_out,
                                    got.done_res, got.is_empty, got.is_full,
                                    got.has_newline));
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_test
    int kind;
    int n;
    foreach (ops_seen[i]) ops_seen[i] = 0;

    // Directed beats: empty cases, extreme bytes, backspace over newlines, mark clearing.
    push_cmd(MODE_REMOVE, 8'h5A);
    push_cmd(MODE_UNINSERT, 8'hA5);
    push_cmd(MODE_UNUSED, 8'hFF);
    push_cmd(MODE_INSERT, 8'h00);
    push_cmd(MODE_INSERT, 8'hFF);
    push_cmd(MODE_INSERT, NEWLINE_BYTE);
    push_cmd(MODE_INSERT, 8'h41);
    push_cmd(MODE_UNUSED, 8'h00);
    push_cmd(MODE_UNINSERT, 8'h00);
    push_cmd(MODE_UNINSERT, 8'h00);
    push_cmd(MODE_INSERT, NEWLINE_BYTE);
    push_cmd(MODE_INSERT, 8'h62);
    push_cmd(MODE_INSERT, NEWLINE_BYTE);
    // Taking back the latest newline leaves none marked although one is still queued.
    push_cmd(MODE_UNINSERT, 8'h00);
    push_cmd(MODE_REMOVE, 8'h00);
    push_cmd(MODE_REMOVE, 8'h00);
    push_cmd(MODE_REMOVE, 8'h00);
    push_cmd(MODE_REMOVE, 8'h00);
    push_cmd(MODE_REMOVE, 8'h00);
    push_cmd(MODE_REMOVE, 8'h00);
    push_cmd(MODE_INSERT, 8'hAA);
    push_cmd(MODE_INSERT, NEWLINE_BYTE);
    push_cmd(MODE_REMOVE, 8'h00);
    // The head passes the marked newline here.
    push_cmd(MODE_REMOVE, 8'h00);
    push_cmd(MODE_UNINSERT, 8'h00);

    // Fill past full so inserts get dropped, then drain past empty.
    for (int i = 0; i < DEPTH + 2; i++) push_cmd(MODE_INSERT, pick_char());
    for (int i = 0; i < DEPTH + 1; i++) push_cmd(MODE_REMOVE, pick_char());

    // Random part: mostly bursts of well-formed edits, some loose single commands.
    while (n_items < TARGET_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(DEPTH - 8, DEPTH + 4)
                                        : $urandom_range(1, 10);
        repeat (n) push_cmd(MODE_INSERT, pick_char());
      end else if (kind < 30) begin
        n = ($urandom_range(0, 5) == 0) ? DEPTH + 2 : $urandom_range(1, 12);
        repeat (n) push_cmd(MODE_REMOVE, pick_char());
      end else if (kind < 40) begin
        repeat ($urandom_range(1, 6)) push_cmd(MODE_UNINSERT, pick_char());
      end else if (kind < 55) begin
        // One typed line, sometimes with a backspace at its end.
        repeat ($urandom_range(1, 8)) push_cmd(MODE_INSERT, CHAR_W'($urandom_range(32, 126)));
        push_cmd(MODE_INSERT, NEWLINE_BYTE);
        if ($urandom_range(0, 2) == 0) push_cmd(MODE_UNINSERT, pick_char());
      end else begin
        push_cmd(2'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)));
      end
    end

    // Synchronous reset, held low from time zero and released at a falling edge.
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every command to be taken and every result beat to arrive.
    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Covered %0d inserts, %0d uninserts, %0d removes, %0d unused-mode beats; %0d beats checked.",
             ops_seen[MODE_INSERT], ops_seen[MODE_UNINSERT], ops_seen[MODE_REMOVE],
             ops_seen[MODE_UNUSED], beats_checked);
    $display("Saw %0d inserts dropped on full, %0d empty takes, %0d full flags, %0d newline flags; %0d mismatches.",
             full_drops, empty_hits, full_flags, newline_flags, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("char_fifo_with_newline_tracking_unit_tb passed");
    end else begin
      $display("char_fifo_with_newline_tracking_unit_tb failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #5ms;
    $display("Timeout with %0d commands queued and %0d results outstanding.",
             cmd_backlog.size(), pending_results.size());
    $display("char_fifo_with_newline_tracking_unit_tb failed");
    $finish;
  end

endmodule
